// ===== rtl/phdf_pkg.sv =====
`default_nettype none

package phdf_pkg;

   // Header layout: sync, size code, check low, check high, control, header xor.
   localparam int HEADER_BYTES = 6;
   localparam int POS_SYNC     = 0;
   localparam int POS_SIZE     = 1;
   localparam int POS_CHECK_LO = 2;
   localparam int POS_CHECK_HI = 3;
   localparam int POS_CONTROL  = 4;
   localparam int POS_XOR      = 5;

   localparam int COUNT_W = 3;

   localparam logic [7:0]  CONTROL_SIZE_CODE = 8'd9;
   localparam logic [7:0]  SYNC_RESET        = 8'd16;
   localparam logic [15:0] CHECK_WORD_RESET  = 16'd43690;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYNC_VALUE = 1'b0,
      CSR_CHECK_WORD = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      STAT_GOOD_CONTROL = 2'd0,
      STAT_DATA         = 2'd1,
      STAT_BAD_XOR      = 2'd2,
      STAT_BAD_CHECK    = 2'd3
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  size_code;
      logic [7:0]  control_byte;
      logic [15:0] check_field;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/phdf_window.sv =====
`default_nettype none

// Holds the partial header and judges it when the sixth byte arrives. On a
// reject it realigns to a held sync byte or empties. One byte is absorbed per step.
module phdf_window (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                step,
   input  wire logic [7:0]          rx_byte,
   input  wire logic [7:0]          sync_value,
   input  wire logic [15:0]         check_word,
   output logic                     emit,
   output phdf_pkg::result_type     result
);

   localparam int HB = phdf_pkg::HEADER_BYTES;

   logic [7:0] win_ff [0:HB-2];
   logic [7:0] win_in [0:HB-2];
   logic [phdf_pkg::COUNT_W-1:0] count_ff, count_in;

   logic [7:0]  w [0:HB-1];
   logic        full;
   logic        hdr_ok;
   logic [7:0]  xr;
   logic [15:0] check;
   logic [15:0] sum;
   logic        bad;
   logic        found;
   logic [phdf_pkg::COUNT_W-1:0] pos;
   logic [phdf_pkg::COUNT_W:0]   src;
   phdf_pkg::status_type status;

   always_comb begin
      for (int i = 0; i < HB - 1; i++) begin
         w[i] = win_ff[i];
      end
      w[HB-1] = rx_byte;
   end

   assign full   = (count_ff == phdf_pkg::COUNT_W'(HB - 1));
   assign hdr_ok = (w[phdf_pkg::POS_SYNC] == sync_value);
   assign xr     = w[phdf_pkg::POS_SIZE] ^ w[phdf_pkg::POS_CHECK_LO]
                 ^ w[phdf_pkg::POS_CHECK_HI] ^ w[phdf_pkg::POS_CONTROL];
   assign check  = {w[phdf_pkg::POS_CHECK_HI], w[phdf_pkg::POS_CHECK_LO]};
   assign sum    = check + {8'd0, w[phdf_pkg::POS_CONTROL]};

   always_comb begin
      if (xr != w[phdf_pkg::POS_XOR]) begin
         status = phdf_pkg::STAT_BAD_XOR;
      end else if (w[phdf_pkg::POS_SIZE] != phdf_pkg::CONTROL_SIZE_CODE) begin
         status = phdf_pkg::STAT_DATA;
      end else if (sum != check_word) begin
         status = phdf_pkg::STAT_BAD_CHECK;
      end else begin
         status = phdf_pkg::STAT_GOOD_CONTROL;
      end
   end

   assign bad = !hdr_ok || status == phdf_pkg::STAT_BAD_XOR
                || status == phdf_pkg::STAT_BAD_CHECK;

   // The lowest position from one onward that holds the sync byte wins.
   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int p = HB - 1; p >= 1; p--) begin
         if (w[p] == sync_value) begin
            found = 1'b1;
            pos   = phdf_pkg::COUNT_W'(p);
         end
      end
   end

   always_comb begin
      src = '0;
      for (int i = 0; i < HB - 1; i++) begin
         win_in[i] = win_ff[i];
      end
      count_in = count_ff;
      if (step) begin
         if (!full) begin
            for (int i = 0; i < HB - 1; i++) begin
               if (count_ff == phdf_pkg::COUNT_W'(i)) begin
                  win_in[i] = rx_byte;
               end
            end
            count_in = count_ff + phdf_pkg::COUNT_W'(1);
         end else if (bad && found) begin
            for (int i = 0; i < HB - 1; i++) begin
               src = (phdf_pkg::COUNT_W + 1)'(i) + {1'b0, pos};
               if (src < (phdf_pkg::COUNT_W + 1)'(HB)) begin
                  win_in[i] = w[src[phdf_pkg::COUNT_W-1:0]];
               end
            end
            count_in = phdf_pkg::COUNT_W'(HB) - pos;
         end else begin
            count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HB - 1; i++) begin
         win_ff[i] <= win_in[i];
      end
   end

   assign emit                = step && full && hdr_ok;
   assign result.status       = status;
   assign result.size_code    = w[phdf_pkg::POS_SIZE];
   assign result.control_byte = w[phdf_pkg::POS_CONTROL];
   assign result.check_field  = check;

endmodule

`default_nettype wire

// ===== rtl/packet_header_deframer.sv =====
// Path: the byte that completes a header passes the input register, is judged
//   in the window and loads the output register that drives rsp_valid.
// Throughput: one byte per cycle, sustained, as long as results are taken.
// Reset: synchronous, active high; clears the fill count and both valid flags
//   and loads the sync value (16) and the check word (43690).
`default_nettype none

// Header deframer top level.
//
// Bytes enter an input register. The next stage absorbs the registered byte
// into the header window; when the window holds six bytes it is judged in the
// same cycle and, if the first byte is the sync value, a result is loaded into
// the output register. The window is then emptied or realigned to the next
// sync byte, so the following byte can be taken straight away.
//
// The input stage moves forward whenever the output register is empty or is
// being drained in the same cycle. A byte that completes no header never needs
// the output register, but the stage still waits on it for simplicity of the
// control; this only matters while the consumer stalls.
module packet_header_deframer (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [7:0]             req_rx_byte,

   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output phdf_pkg::status_type        rsp_status,
   output logic [7:0]                  rsp_size_code,
   output logic [7:0]                  rsp_control_byte,
   output logic [15:0]                 rsp_check_field,

   input  wire logic                   csr_wr_en,
   input  wire logic [phdf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [phdf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers.
   logic [7:0]  sync_ff, sync_in;
   logic [15:0] check_word_ff, check_word_in;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // Output register.
   logic                 out_valid_ff, out_valid_in;
   phdf_pkg::result_type out_ff, out_in;

   logic                 advance;
   logic                 step;
   logic                 emit;
   phdf_pkg::result_type result;

   // Configuration writes land directly; the user must only let them occur while the block is idle (not enforced).
   always_comb begin
      sync_in       = sync_ff;
      check_word_in = check_word_ff;
      if (csr_wr_en) begin
         case (phdf_pkg::csr_index_type'(csr_index))
            phdf_pkg::CSR_SYNC_VALUE: sync_in       = csr_wdata[7:0];
            phdf_pkg::CSR_CHECK_WORD: check_word_in = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff       <= phdf_pkg::SYNC_RESET;
         check_word_ff <= phdf_pkg::CHECK_WORD_RESET;
      end else begin
         sync_ff       <= sync_in;
         check_word_ff <= check_word_in;
      end
   end

   // The window stage may run when the output register has room for a result.
   assign advance   = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   phdf_window u_window (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .rx_byte    (in_byte_ff),
      .sync_value (sync_ff),
      .check_word (check_word_ff),
      .emit       (emit),
      .result     (result)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      out_ff     <= out_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_ff.status;
   assign rsp_size_code    = out_ff.size_code;
   assign rsp_control_byte = out_ff.control_byte;
   assign rsp_check_field  = out_ff.check_field;

endmodule

`default_nettype wire

// ===== rtl/phdf_checker.sv =====
`default_nettype none

module phdf_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_ready,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire phdf_pkg::status_type   rsp_status,
   input wire logic [7:0]             rsp_size_code,
   input wire logic [7:0]             rsp_control_byte,
   input wire logic [15:0]            rsp_check_field
);

   // A result that is not taken stays offered unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_size_code) && $stable(rsp_control_byte)
         && $stable(rsp_check_field))
      else $error("result changed while stalled");

   // A result rising from an empty output register comes from a byte whose
   // transfer filled the input register before the result was loaded.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result appeared without a byte transfer");

   // Control statuses go with the control size code, data status never does.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == phdf_pkg::STAT_GOOD_CONTROL
                    || rsp_status == phdf_pkg::STAT_BAD_CHECK)
      |-> rsp_size_code == phdf_pkg::CONTROL_SIZE_CODE)
      else $error("control status with a data size code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == phdf_pkg::STAT_DATA
      |-> rsp_size_code != phdf_pkg::CONTROL_SIZE_CODE)
      else $error("data status with the control size code");

endmodule

bind packet_header_deframer phdf_checker u_phdf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_size_code    (rsp_size_code),
   .rsp_control_byte (rsp_control_byte),
   .rsp_check_field  (rsp_check_field)
);

`default_nettype wire
